[hdl/mnw_pkg.sv]
// Shared types and constants for the metatile nametable writer.
`default_nettype none

package mnw_pkg;

  // Command codes carried in the request.
  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_PLACE     = 2'd1,
    CMD_READ_TILE = 2'd2,
    CMD_READ_ATTR = 2'd3
  } cmd_e_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_FETCH,
    S_TL,
    S_TR,
    S_BL,
    S_BR,
    S_DONE
  } state_t;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // One request transaction.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] metatile_index;
    logic [4:0] tile_x;
    logic [4:0] tile_y;
    logic [7:0] top_left_tile;
    logic [7:0] top_right_tile;
    logic [7:0] bottom_left_tile;
    logic [7:0] bottom_right_tile;
    logic [1:0] palette_choice;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic       status;
    logic [7:0] read_value;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/metatile_nametable_writer_top.sv]
// Top level: command sequencer around the metatile, tile and attribute memories.
//
// One command is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and cannot be held off. Load and any
// command with coordinates outside the nametable go from S_ISSUE to S_DONE, the
// two reads pass through S_FETCH, and a placement through S_TL to S_BR, as the four
// tile bytes go through the single write port of the tile RAM one per cycle.
// A new command may be accepted in the cycle that shows a result.
// No clearing pass is needed after reset.
`default_nettype none

module metatile_nametable_writer_top #(
  parameter int WIDTH_TILES    = 32,
  parameter int HEIGHT_TILES   = 30,
  parameter int METATILE_COUNT = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire mnw_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output mnw_pkg::rsp_t      result
);

  localparam int AttrCols = (WIDTH_TILES + 3) / 4;
  localparam int AttrRows = (HEIGHT_TILES + 3) / 4;
  localparam int AttrSize = AttrCols * AttrRows;
  localparam int AttrAw   = $clog2(AttrSize);
  localparam int NtSize   = WIDTH_TILES * HEIGHT_TILES;
  localparam int NtAw     = $clog2(NtSize);
  localparam int MiAw     = $clog2(METATILE_COUNT);
  localparam int SumW     = 13;

  localparam logic [6:0]      Width7  = 7'(WIDTH_TILES);
  localparam logic [6:0]      Height7 = 7'(HEIGHT_TILES);
  localparam logic [SumW-1:0] WidthS  = SumW'(WIDTH_TILES);
  localparam logic [SumW-1:0] ColsS   = SumW'(AttrCols);

  mnw_pkg::state_t state;
  mnw_pkg::state_t state_next;
  mnw_pkg::req_t   req;
  mnw_pkg::cmd_e_t cmd;

  logic            status;
  logic [7:0]      value;
  logic [6:0]      x7;
  logic [6:0]      y7;
  logic            place_bad;
  logic            read_bad;
  logic [MiAw-1:0] mi_lut [256];
  logic [MiAw-1:0] mi;
  logic [SumW-1:0] base_sum;
  logic [SumW-1:0] attr_sum;
  logic [SumW-1:0] tile_off;
  logic [NtAw-1:0] tile_addr;
  logic [AttrAw-1:0] attr_addr;
  logic [2:0]      attr_sh;
  logic [7:0]      attr_new;

  logic            meta_re;
  logic            meta_we;
  logic [31:0]     meta_tiles;
  logic [1:0]      meta_pal;
  logic            tile_re;
  logic            tile_we;
  logic [7:0]      tile_wdata;
  logic [7:0]      tile_rdata;
  logic            attr_re;
  logic            attr_we;
  logic [7:0]      attr_rdata;

  // Reduction of the metatile index modulo the table size, as a constant table.
  for (genvar i = 0; i < 256; i++) begin : g_mi_lut
    assign mi_lut[i] = MiAw'(i % METATILE_COUNT);
  end

  assign cmd = mnw_pkg::cmd_e_t'(req.command);
  assign mi  = mi_lut[req.metatile_index];

  // Range checks for placement and for reads.
  assign x7        = {2'b00, req.tile_x};
  assign y7        = {2'b00, req.tile_y};
  assign place_bad = (x7 + 7'd1 >= Width7) || (y7 + 7'd1 >= Height7);
  assign read_bad  = (x7 >= Width7) || (y7 >= Height7);

  // Addresses of the tile block and of the covering attribute byte.
  assign base_sum  = SumW'(req.tile_y) * WidthS + SumW'(req.tile_x);
  assign tile_addr = NtAw'(base_sum + tile_off);
  assign attr_sum  = SumW'(req.tile_y[4:2]) * ColsS + SumW'(req.tile_x[4:2]);
  assign attr_addr = AttrAw'(attr_sum);

  // Replace the two palette bits of the quadrant that holds the top-left tile.
  assign attr_sh = {req.tile_y[1], req.tile_x[1], 1'b0};
  always_comb begin
    attr_new = attr_rdata;
    attr_new[attr_sh +: 2] = meta_pal;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      mnw_pkg::S_IDLE, mnw_pkg::S_DONE: begin
        state_next = start ? mnw_pkg::S_ISSUE : mnw_pkg::S_IDLE;
      end
      mnw_pkg::S_ISSUE: begin
        unique case (cmd)
          mnw_pkg::CMD_LOAD:  state_next = mnw_pkg::S_DONE;
          mnw_pkg::CMD_PLACE: state_next = place_bad ? mnw_pkg::S_DONE : mnw_pkg::S_TL;
          default:            state_next = read_bad ? mnw_pkg::S_DONE : mnw_pkg::S_FETCH;
        endcase
      end
      mnw_pkg::S_FETCH: state_next = mnw_pkg::S_DONE;
      mnw_pkg::S_TL:    state_next = mnw_pkg::S_TR;
      mnw_pkg::S_TR:    state_next = mnw_pkg::S_BL;
      mnw_pkg::S_BL:    state_next = mnw_pkg::S_BR;
      mnw_pkg::S_BR:    state_next = mnw_pkg::S_DONE;
      default:          state_next = mnw_pkg::S_IDLE;
    endcase
  end

  // Output and memory control logic.
  always_comb begin
    busy       = 1'b1;
    done       = 1'b0;
    meta_re    = 1'b0;
    meta_we    = 1'b0;
    tile_re    = 1'b0;
    tile_we    = 1'b0;
    tile_off   = '0;
    tile_wdata = meta_tiles[7:0];
    attr_re    = 1'b0;
    attr_we    = 1'b0;
    unique case (state)
      mnw_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      mnw_pkg::S_DONE: begin
        busy = 1'b0;
        done = 1'b1;
      end
      mnw_pkg::S_ISSUE: begin
        unique case (cmd)
          mnw_pkg::CMD_LOAD: begin
            meta_we = 1'b1;
          end
          mnw_pkg::CMD_PLACE: begin
            meta_re = !place_bad;
            attr_re = !place_bad;
          end
          mnw_pkg::CMD_READ_TILE: begin
            tile_re = !read_bad;
          end
          default: begin
            attr_re = !read_bad;
          end
        endcase
      end
      mnw_pkg::S_TL: begin
        tile_we = 1'b1;
        attr_we = 1'b1;
      end
      mnw_pkg::S_TR: begin
        tile_we    = 1'b1;
        tile_off   = SumW'(1);
        tile_wdata = meta_tiles[15:8];
      end
      mnw_pkg::S_BL: begin
        tile_we    = 1'b1;
        tile_off   = WidthS;
        tile_wdata = meta_tiles[23:16];
      end
      mnw_pkg::S_BR: begin
        tile_we    = 1'b1;
        tile_off   = WidthS + SumW'(1);
        tile_wdata = meta_tiles[31:24];
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
    if (state == mnw_pkg::S_ISSUE) begin
      value <= 8'h00;
      unique case (cmd)
        mnw_pkg::CMD_LOAD:  status <= mnw_pkg::STATUS_OK;
        mnw_pkg::CMD_PLACE: status <= place_bad ? mnw_pkg::STATUS_OUTSIDE : mnw_pkg::STATUS_OK;
        default:            status <= read_bad ? mnw_pkg::STATUS_OUTSIDE : mnw_pkg::STATUS_OK;
      endcase
    end
    if (state == mnw_pkg::S_FETCH) begin
      value <= (cmd == mnw_pkg::CMD_READ_TILE) ? tile_rdata : attr_rdata;
    end
  end

  assign result.status     = status;
  assign result.read_value = value;

  // Metatile table.
  mnw_meta_store #(
    .Depth (METATILE_COUNT),
    .Aw    (MiAw)
  ) u_meta (
    .clk    (clk),
    .rst    (rst),
    .addr   (mi),
    .re     (meta_re),
    .we     (meta_we),
    .wtiles ({req.bottom_right_tile, req.bottom_left_tile,
              req.top_right_tile, req.top_left_tile}),
    .wpal   (req.palette_choice),
    .rtiles (meta_tiles),
    .rpal   (meta_pal)
  );

  // Nametable tile bytes.
  mnw_tile_ram #(
    .Depth (NtSize),
    .Aw    (NtAw)
  ) u_tiles (
    .clk   (clk),
    .addr  (tile_addr),
    .re    (tile_re),
    .we    (tile_we),
    .wdata (tile_wdata),
    .rdata (tile_rdata)
  );

  // Nametable attribute bytes.
  mnw_attr_store #(
    .Depth (AttrSize),
    .Aw    (AttrAw)
  ) u_attr (
    .clk   (clk),
    .rst   (rst),
    .addr  (attr_addr),
    .re    (attr_re),
    .we    (attr_we),
    .wdata (attr_new),
    .rdata (attr_rdata)
  );

endmodule

`default_nettype wire

[hdl/mnw_meta_store.sv]
// Metatile table: four tile bytes and a palette number per entry.
`default_nettype none

module mnw_meta_store #(
  parameter int Depth = 256,
  parameter int Aw    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [Aw-1:0] addr,
  input  wire logic          re,
  input  wire logic          we,
  input  wire logic [31:0]   wtiles,
  input  wire logic [1:0]    wpal,
  output logic      [31:0]   rtiles,
  output logic      [1:0]    rpal
);

  logic [31:0]      tile_mem [Depth];
  logic [1:0]       pal_mem  [Depth];
  logic [Depth-1:0] valid;
  logic [1:0]       pal_q;
  logic             valid_q;

  // Tile bytes have no reset value; the user must read them only after a load, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (we) begin
      tile_mem[addr] <= wtiles;
      pal_mem[addr]  <= wpal;
    end
    if (re) begin
      rtiles <= tile_mem[addr];
      pal_q  <= pal_mem[addr];
    end
  end

  // Palette numbers read as zero until their entry is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[addr] <= 1'b1;
      end
      if (re) begin
        valid_q <= valid[addr];
      end
    end
  end

  assign rpal = valid_q ? pal_q : 2'b00;

endmodule

`default_nettype wire

[hdl/mnw_attr_store.sv]
// Attribute byte store, all zero after reset.
`default_nettype none

module mnw_attr_store #(
  parameter int Depth = 64,
  parameter int Aw    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [Aw-1:0] addr,
  input  wire logic          re,
  input  wire logic          we,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] valid;
  logic [7:0]       data_q;
  logic             valid_q;

  // Storage array with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      data_q <= mem[addr];
    end
  end

  // Per-entry valid bits stand in for the zero reset of the array.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[addr] <= 1'b1;
      end
      if (re) begin
        valid_q <= valid[addr];
      end
    end
  end

  assign rdata = valid_q ? data_q : 8'h00;

endmodule

`default_nettype wire

[hdl/mnw_tile_ram.sv]
// Single-port nametable tile RAM with a registered read.
`default_nettype none

module mnw_tile_ram #(
  parameter int Depth = 960,
  parameter int Aw    = 10
) (
  input  wire logic          clk,
  input  wire logic [Aw-1:0] addr,
  input  wire logic          re,
  input  wire logic          we,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [Depth];

  // One access per cycle; tile bytes have no reset value.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[tb/nametable_shadow_check.sv]
// Checker that shadows the metatile and nametable stores and compares every result.
`timescale 1ns / 1ps

module nametable_shadow_check
  import mnw_pkg::*;
#(
  parameter int WIDTH_TILES    = 32,
  parameter int HEIGHT_TILES   = 30,
  parameter int METATILE_COUNT = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic done,
  input  rsp_t result,
  output int   mismatch_count,
  output int   outstanding
);

  localparam int ATTR_COLS = (WIDTH_TILES + 3) / 4;
  localparam int ATTR_ROWS = (HEIGHT_TILES + 3) / 4;

  // Shadow copies of the block's three stores, with the metatile table split into tiles and palettes.
  logic [31:0] mt_tiles   [METATILE_COUNT];
  logic [1:0]  mt_palette [METATILE_COUNT];
  logic [7:0]  nt_tiles   [WIDTH_TILES * HEIGHT_TILES];
  logic [7:0]  nt_attr    [ATTR_COLS * ATTR_ROWS];

  // Results owed by the block, oldest first.
  rsp_t owed_results[$];

  initial begin
    foreach (mt_tiles[i]) mt_tiles[i] = '0;
    foreach (mt_palette[i]) mt_palette[i] = '0;
    foreach (nt_tiles[i]) nt_tiles[i] = '0;
    foreach (nt_attr[i]) nt_attr[i] = '0;
    mismatch_count = 0;
    outstanding = 0;
  end

  // Apply one command to the shadow stores and return the result it should give.
  function automatic rsp_t apply_command(req_t r);
    rsp_t rsp;
    int   x;
    int   y;
    int   mi;
    int   base;
    int   slot;
    int   sh;
    logic [31:0] t;
    rsp = '0;
    rsp.status = STATUS_OK;
    x = r.tile_x;
    y = r.tile_y;
    mi = r.metatile_index % METATILE_COUNT;
    slot = (y / 4) * ATTR_COLS + (x / 4);
    case (r.command)
      CMD_LOAD: begin
        mt_tiles[mi] = {r.bottom_right_tile, r.bottom_left_tile,
                        r.top_right_tile, r.top_left_tile};
        mt_palette[mi] = r.palette_choice;
      end
      CMD_PLACE: begin
        if (x + 1 >= WIDTH_TILES || y + 1 >= HEIGHT_TILES) begin
          rsp.status = STATUS_OUTSIDE;
        end else begin
          t = mt_tiles[mi];
          base = y * WIDTH_TILES + x;
          nt_tiles[base] = t[7:0];
          nt_tiles[base + 1] = t[15:8];
          nt_tiles[base + WIDTH_TILES] = t[23:16];
          nt_tiles[base + WIDTH_TILES + 1] = t[31:24];
          // The top-left tile alone picks the quadrant, aligned or not.
          sh = (((x % 4) / 2) + ((y % 4) / 2) * 2) * 2;
          nt_attr[slot][sh +: 2] = mt_palette[mi];
        end
      end
      default: begin
        if (x >= WIDTH_TILES || y >= HEIGHT_TILES) begin
          rsp.status = STATUS_OUTSIDE;
        end else if (r.command == CMD_READ_TILE) begin
          rsp.read_value = nt_tiles[y * WIDTH_TILES + x];
        end else begin
          rsp.read_value = nt_attr[slot];
        end
      end
    endcase
    return rsp;
  endfunction

  // Compare results first, then record the transaction accepted at this edge,
  // since a new command may be taken in the cycle that shows a result.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result with nothing owed: status=%0d value=%02h",
                     $realtime, result.status, result.read_value);
          end
        end else begin
          want = owed_results.pop_front();
          if (result.status !== want.status || result.read_value !== want.read_value) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch: status exp %0d got %0d, value exp %02h got %02h",
                       $realtime, want.status, result.status,
                       want.read_value, result.read_value);
            end
          end
        end
      end
      if (start && !busy) begin
        owed_results.push_back(apply_command(request));
      end
    end
    outstanding = owed_results.size();
  end

endmodule

[tb/testbench.sv]
// Top of the testbench: clock, reset, command stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import mnw_pkg::*;

  localparam int WIDTH_TILES    = 32;
  localparam int HEIGHT_TILES   = 30;
  localparam int METATILE_COUNT = 256;
  localparam int RANDOM_ITEMS   = 1950;

  logic clk = 1'b0;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  rsp_t result;
  int   mismatch_count;
  int   outstanding;

  // What the stimulus has written so far, so that no unwritten entry is read.
  bit tile_written [WIDTH_TILES * HEIGHT_TILES];
  bit mt_loaded    [METATILE_COUNT];
  int written_tiles[$];
  int loaded_entries[$];
  int burst_left;

  metatile_nametable_writer_top #(
    .WIDTH_TILES   (WIDTH_TILES),
    .HEIGHT_TILES  (HEIGHT_TILES),
    .METATILE_COUNT(METATILE_COUNT)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  nametable_shadow_check #(
    .WIDTH_TILES   (WIDTH_TILES),
    .HEIGHT_TILES  (HEIGHT_TILES),
    .METATILE_COUNT(METATILE_COUNT)
  ) shadow_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .done          (done),
    .result        (result),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Given code, index and place, the rest random; callers overwrite what matters.
  function automatic req_t coord_req(logic [1:0] cmd, int idx, int x, int y);
    req_t r;
    r.command = cmd;
    r.metatile_index = idx[7:0];
    r.tile_x = x[4:0];
    r.tile_y = y[4:0];
    r.top_left_tile = 8'($urandom);
    r.top_right_tile = 8'($urandom);
    r.bottom_left_tile = 8'($urandom);
    r.bottom_right_tile = 8'($urandom);
    r.palette_choice = 2'($urandom);
    return r;
  endfunction

  function automatic req_t load_req(int idx, logic [7:0] tl, logic [7:0] tr,
                                    logic [7:0] bl, logic [7:0] br, logic [1:0] pal);
    req_t r;
    r = coord_req(CMD_LOAD, idx, $urandom_range(0, 31), $urandom_range(0, 31));
    r.top_left_tile = tl;
    r.top_right_tile = tr;
    r.bottom_left_tile = bl;
    r.bottom_right_tile = br;
    r.palette_choice = pal;
    return r;
  endfunction

  // Offer one transaction, with sender gaps between bursts of random length.
  task automatic send_command(input req_t r);
    int gap;
    int pos;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (r.command == CMD_LOAD && !mt_loaded[r.metatile_index]) begin
      mt_loaded[r.metatile_index] = 1'b1;
      loaded_entries.push_back(r.metatile_index);
    end
    if (r.command == CMD_PLACE && r.tile_x + 1 < WIDTH_TILES &&
        r.tile_y + 1 < HEIGHT_TILES) begin
      foreach (tile_written[i]) begin
        pos = r.tile_y * WIDTH_TILES + r.tile_x;
        if ((i == pos || i == pos + 1 || i == pos + WIDTH_TILES ||
             i == pos + WIDTH_TILES + 1) && !tile_written[i]) begin
          tile_written[i] = 1'b1;
          written_tiles.push_back(i);
        end
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int   roll;
    int   pos;
    int   x;
    int   y;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: attribute bytes after reset, extreme loads, placements at
    // the corners, unaligned placements, off-edge placements and outside reads.
    send_command(coord_req(CMD_READ_ATTR, 0, 0, 0));
    send_command(coord_req(CMD_READ_ATTR, 255, 31, 29));
    send_command(load_req(0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
    send_command(load_req(255, 8'hff, 8'hff, 8'hff, 8'hff, 2'd3));
    send_command(load_req(8'h5a, 8'h12, 8'h34, 8'h56, 8'h78, 2'd2));
    send_command(load_req(1, 8'ha5, 8'h0f, 8'hf0, 8'h5a, 2'd1));
    send_command(coord_req(CMD_PLACE, 255, 0, 0));
    send_command(coord_req(CMD_PLACE, 8'h5a, 30, 28));
    send_command(coord_req(CMD_PLACE, 1, 3, 2));
    send_command(coord_req(CMD_PLACE, 0, 1, 1));
    send_command(coord_req(CMD_PLACE, 1, 31, 0));
    send_command(coord_req(CMD_PLACE, 1, 0, 29));
    send_command(coord_req(CMD_PLACE, 255, 31, 31));
    send_command(coord_req(CMD_READ_TILE, 0, 0, 0));
    send_command(coord_req(CMD_READ_TILE, 0, 1, 1));
    send_command(coord_req(CMD_READ_TILE, 0, 31, 29));
    send_command(coord_req(CMD_READ_TILE, 0, 4, 3));
    send_command(coord_req(CMD_READ_TILE, 0, 0, 30));
    send_command(coord_req(CMD_READ_TILE, 0, 31, 31));
    send_command(coord_req(CMD_READ_ATTR, 0, 0, 0));
    send_command(coord_req(CMD_READ_ATTR, 0, 31, 29));
    send_command(coord_req(CMD_READ_ATTR, 0, 4, 2));
    send_command(coord_req(CMD_READ_ATTR, 0, 5, 30));

    // Random part: loads, placements that mostly land inside the nametable,
    // and reads of written tiles and of attribute bytes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15 || loaded_entries.size() == 0) begin
        send_command(load_req($urandom_range(0, 255), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 2'($urandom)));
      end else if (roll < 50) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            x = WIDTH_TILES - 1;
            y = $urandom_range(0, 31);
          end else begin
            x = $urandom_range(0, 31);
            y = $urandom_range(HEIGHT_TILES - 1, 31);
          end
        end else begin
          x = $urandom_range(0, WIDTH_TILES - 2);
          y = $urandom_range(0, HEIGHT_TILES - 2);
        end
        pos = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
        send_command(coord_req(CMD_PLACE, pos, x, y));
      end else if (roll < 75 && written_tiles.size() != 0) begin
        if ($urandom_range(0, 7) == 0) begin
          send_command(coord_req(CMD_READ_TILE, $urandom_range(0, 255),
                                 $urandom_range(0, 31), $urandom_range(HEIGHT_TILES, 31)));
        end else begin
          pos = written_tiles[$urandom_range(0, written_tiles.size() - 1)];
          send_command(coord_req(CMD_READ_TILE, $urandom_range(0, 255),
                                 pos % WIDTH_TILES, pos / WIDTH_TILES));
        end
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          y = $urandom_range(HEIGHT_TILES, 31);
        end else begin
          y = $urandom_range(0, HEIGHT_TILES - 1);
        end
        send_command(coord_req(CMD_READ_ATTR, $urandom_range(0, 255),
                               $urandom_range(0, 31), y));
      end
    end
    start <= 1'b0;

    // Drain the owed results, then keep watching for stray ones before the verdict.
    do @(negedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
